// ===== rtl/core/ictf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ictf_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ANGLE_FRAC   = 16;
    localparam int TAB_FRAC     = 24;
    localparam int VEC_SHIFT    = 12;
    localparam int ACC_SHIFT    = TAB_FRAC - ANGLE_FRAC;
    localparam int GYRO_SHIFT   = 32 - ANGLE_FRAC;
    localparam int BLEND_FRAC   = 16;
    localparam int LEN_SHIFT    = 30;

    localparam int VW      = 34;
    localparam int IDX_W   = 5;
    localparam int OFF_W   = 17;
    localparam int DIFF_W  = 18;
    localparam int DT_W    = 9;
    localparam int GD_W    = DIFF_W + DT_W;
    localparam int MOP_W   = 33;
    localparam int PROD_W  = 2 * MOP_W;
    localparam int ADDR_W  = 5;
    localparam int RIDX_W  = 3;

    localparam logic [29:0]       INV_GAIN_Q30 = 30'd652032875;
    localparam logic [31:0]       DT_MAX       = 32'd500;
    localparam logic [DT_W-1:0]   DT_DEF       = DT_W'(10);
    localparam logic [31:0]       GAIN_RST     = 32'd32768;
    localparam logic [15:0]       ALPHA_RST    = 16'd64880;

    localparam logic [RIDX_W-1:0] REG_OFF_AX = 3'd0;
    localparam logic [RIDX_W-1:0] REG_OFF_AY = 3'd1;
    localparam logic [RIDX_W-1:0] REG_OFF_AZ = 3'd2;
    localparam logic [RIDX_W-1:0] REG_OFF_GX = 3'd3;
    localparam logic [RIDX_W-1:0] REG_OFF_GY = 3'd4;
    localparam logic [RIDX_W-1:0] REG_GAIN   = 3'd5;
    localparam logic [RIDX_W-1:0] REG_ALPHA  = 3'd6;

    typedef logic signed [VW-1:0] t_vec;

    localparam t_vec Z_QUARTER = VW'(90) <<< TAB_FRAC;

    typedef struct packed {
        logic signed [OFF_W-1:0] off_ax;
        logic signed [OFF_W-1:0] off_ay;
        logic signed [OFF_W-1:0] off_az;
        logic signed [OFF_W-1:0] off_gx;
        logic signed [OFF_W-1:0] off_gy;
        logic [31:0]             gain;
        logic [15:0]             alpha;
    } t_cfg;

    typedef struct packed {
        logic valid;
        t_vec x;
        t_vec y;
        t_vec z;
    } t_cell;

    typedef struct packed {
        logic valid;
        t_vec x;
        t_vec y;
    } t_vreq;

    typedef struct packed {
        logic valid;
        t_vec z;
        t_vec mag;
    } t_vres;

    // atan(2^-i) in degrees, Q.24
    function automatic t_vec atan_q24(input logic [IDX_W-1:0] i);
        t_vec r;
        case (i)
            5'd0:    r = 34'sd754974720;
            5'd1:    r = 34'sd445687602;
            5'd2:    r = 34'sd235489088;
            5'd3:    r = 34'sd119537938;
            5'd4:    r = 34'sd60000934;
            5'd5:    r = 34'sd30029717;
            5'd6:    r = 34'sd15018523;
            5'd7:    r = 34'sd7509720;
            5'd8:    r = 34'sd3754917;
            5'd9:    r = 34'sd1877466;
            5'd10:   r = 34'sd938734;
            5'd11:   r = 34'sd469367;
            5'd12:   r = 34'sd234684;
            5'd13:   r = 34'sd117342;
            5'd14:   r = 34'sd58671;
            5'd15:   r = 34'sd29335;
            5'd16:   r = 34'sd14668;
            5'd17:   r = 34'sd7334;
            5'd18:   r = 34'sd3667;
            5'd19:   r = 34'sd1833;
            5'd20:   r = 34'sd917;
            5'd21:   r = 34'sd458;
            5'd22:   r = 34'sd229;
            5'd23:   r = 34'sd115;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ictf_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ictf_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [ictf_pkg::IDX_W-1:0]  i_step,
    input  ictf_pkg::t_cell             i_cell,
    output ictf_pkg::t_cell             o_cell
);
    import ictf_pkg::*;

    t_vec cx, cy, cz, dx, dy, w_atan;
    t_vec n_x, n_y, n_z;
    t_vec r_x, r_y, r_z;
    logic r_valid;
    logic w_up;

    assign cx     = i_cell.x;
    assign cy     = i_cell.y;
    assign cz     = i_cell.z;
    assign dx     = cy >>> i_step;
    assign dy     = cx >>> i_step;
    assign w_atan = atan_q24(i_step);
    assign w_up   = ~cy[VW-1];

    assign n_x = w_up ? cx + dx : cx - dx;
    assign n_y = w_up ? cy - dy : cy + dy;
    assign n_z = w_up ? cz + w_atan : cz - w_atan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cell.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_cell = '{valid: r_valid, x: r_x, y: r_y, z: r_z};

endmodule

`default_nettype wire

// ===== rtl/core/ictf_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ictf_chain (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ictf_pkg::t_vreq  i_req,
    output ictf_pkg::t_vres  o_res
);
    import ictf_pkg::*;

    t_vec  qx, qy, px, py, pz;
    logic  w_zero;
    logic  [CORDIC_STEPS-1:0] r_zero;
    t_cell w_link [0:CORDIC_STEPS];

    assign qx     = i_req.x;
    assign qy     = i_req.y;
    assign w_zero = (qx == '0) && (qy == '0);

    // left half plane: rotate by a quarter turn first
    always_comb begin
        px = qx;
        py = qy;
        pz = '0;
        if (qx < 0) begin
            if (qy >= 0) begin
                pz = Z_QUARTER;
                px = qy;
                py = -qx;
            end else begin
                pz = -Z_QUARTER;
                px = -qy;
                py = qx;
            end
        end
    end

    assign w_link[0] = '{valid: i_req.valid, x: px, y: py, z: pz};

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        ictf_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_step (IDX_W'(g)),
            .i_cell (w_link[g]),
            .o_cell (w_link[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        r_zero <= {r_zero[CORDIC_STEPS-2:0], w_zero};
    end

    assign o_res = '{
        valid: w_link[CORDIC_STEPS].valid,
        z:     r_zero[CORDIC_STEPS-1] ? t_vec'(0) : w_link[CORDIC_STEPS].z,
        mag:   r_zero[CORDIC_STEPS-1] ? t_vec'(0) : w_link[CORDIC_STEPS].x
    };

endmodule

`default_nettype wire

// ===== rtl/core/ictf_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ictf_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ictf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output ictf_pkg::t_cfg              o_cfg
);
    import ictf_pkg::*;

    t_cfg r_cfg, n_cfg;
    logic [RIDX_W-1:0] w_idx;
    logic w_wr;

    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_OFF_AX: n_cfg.off_ax = pwdata[OFF_W-1:0];
                REG_OFF_AY: n_cfg.off_ay = pwdata[OFF_W-1:0];
                REG_OFF_AZ: n_cfg.off_az = pwdata[OFF_W-1:0];
                REG_OFF_GX: n_cfg.off_gx = pwdata[OFF_W-1:0];
                REG_OFF_GY: n_cfg.off_gy = pwdata[OFF_W-1:0];
                REG_GAIN:   n_cfg.gain   = pwdata;
                REG_ALPHA:  n_cfg.alpha  = pwdata[15:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{off_ax: '0, off_ay: '0, off_az: '0, off_gx: '0, off_gy: '0,
                       gain: GAIN_RST, alpha: ALPHA_RST};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (w_idx)
            REG_OFF_AX: prdata = 32'($signed(r_cfg.off_ax));
            REG_OFF_AY: prdata = 32'($signed(r_cfg.off_ay));
            REG_OFF_AZ: prdata = 32'($signed(r_cfg.off_az));
            REG_OFF_GX: prdata = 32'($signed(r_cfg.off_gx));
            REG_OFF_GY: prdata = 32'($signed(r_cfg.off_gy));
            REG_GAIN:   prdata = r_cfg.gain;
            REG_ALPHA:  prdata = {16'd0, r_cfg.alpha};
            default:    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/core/imu_complementary_tilt_filter.sv =====
// One item at a time: o_in_stall is high outside ST_IDLE, and ST_FIN holds until the
// output register can take the result. The CORDIC cell row is passed twice per item
// (roll, then pitch on the roll magnitude) and one shared multiplier runs the gyro,
// gain-correction, blend and scaling products in turn.
// Reset: angles and timestamp clear, registers take their defaults; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module imu_complementary_tilt_filter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [15:0]          i_accel_x,
    input  logic signed [15:0]          i_accel_y,
    input  logic signed [15:0]          i_accel_z,
    input  logic signed [15:0]          i_gyro_x,
    input  logic signed [15:0]          i_gyro_y,
    input  logic [31:0]                 i_time_ms,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [15:0]          o_roll_centideg,
    output logic signed [15:0]          o_pitch_centideg,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ictf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import ictf_pkg::*;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_ROLL   = 5'd1;
    localparam logic [4:0] ST_GX     = 5'd2;
    localparam logic [4:0] ST_GXP    = 5'd3;
    localparam logic [4:0] ST_GY     = 5'd4;
    localparam logic [4:0] ST_GYP    = 5'd5;
    localparam logic [4:0] ST_WAIT_R = 5'd6;
    localparam logic [4:0] ST_LEN    = 5'd7;
    localparam logic [4:0] ST_PINJ   = 5'd8;
    localparam logic [4:0] ST_BR     = 5'd9;
    localparam logic [4:0] ST_CR     = 5'd10;
    localparam logic [4:0] ST_CR2    = 5'd11;
    localparam logic [4:0] ST_WAIT_P = 5'd12;
    localparam logic [4:0] ST_PD     = 5'd13;
    localparam logic [4:0] ST_PM     = 5'd14;
    localparam logic [4:0] ST_BP     = 5'd15;
    localparam logic [4:0] ST_CP     = 5'd16;
    localparam logic [4:0] ST_CP2    = 5'd17;
    localparam logic [4:0] ST_FIN    = 5'd18;

    localparam logic signed [PROD_W-1:0] S32_MAX    = PROD_W'(32'sh7FFF_FFFF);
    localparam logic signed [PROD_W-1:0] S32_MIN    = PROD_W'(32'sh8000_0000);
    localparam logic signed [PROD_W-1:0] CENTI_MAX  = PROD_W'(18000);
    localparam logic signed [PROD_W-1:0] CENTI_MIN  = -CENTI_MAX;
    localparam logic signed [PROD_W-1:0] GYRO_HALF  = PROD_W'(1) <<< (GYRO_SHIFT - 1);
    localparam logic signed [PROD_W-1:0] LEN_HALF   = PROD_W'(1) <<< (LEN_SHIFT - 1);
    localparam logic signed [PROD_W-1:0] BLEND_HALF = PROD_W'(1) <<< (BLEND_FRAC - 1);
    localparam logic signed [PROD_W-1:0] CENTI_HALF = PROD_W'(1) <<< (ANGLE_FRAC - 1);
    localparam t_vec                     ACC_HALF   = VW'(1) <<< (ACC_SHIFT - 1);
    localparam logic signed [MOP_W-1:0]  CENTI_SCALE = MOP_W'(100);

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < S32_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = $signed(v[31:0]);
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat_centi(input logic signed [PROD_W-1:0] v);
        logic signed [15:0] r;
        if (v > CENTI_MAX) begin
            r = 16'sd18000;
        end else if (v < CENTI_MIN) begin
            r = -16'sd18000;
        end else begin
            r = $signed(v[15:0]);
        end
        return r;
    endfunction

    t_cfg  w_cfg;
    t_vreq w_req;
    t_vres w_res;

    logic [4:0] r_state, n_state;
    logic [31:0] r_last_time;
    logic signed [31:0] r_roll_angle, r_pitch_angle;
    logic signed [31:0] r_pred_r, r_pred_p;
    logic signed [DIFF_W-1:0] r_ax, r_ay, r_az, r_gx, r_gy;
    logic [DT_W-1:0] r_dt;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [MOP_W-1:0] r_diff;
    t_vec r_acc, r_len;
    logic signed [15:0] r_roll_c, r_pitch_c;
    logic signed [15:0] r_out_roll, r_out_pitch;
    logic r_out_valid;

    logic w_in_acc, w_out_load;
    logic [31:0] w_dt_raw;
    logic [DT_W-1:0] w_dt;
    logic signed [MOP_W-1:0] w_mul_a, w_mul_b;
    logic signed [PROD_W-1:0] w_inc, w_pred_sum, w_len, w_mix, w_centi;
    logic signed [31:0] w_pred, w_blend, w_angle_sel, w_pred_sel;
    t_vec w_res_z, w_acc, w_ax_sc, w_ay_sc, w_az_sc;

    ictf_regs u_regs (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .o_cfg  (w_cfg)
    );

    ictf_chain u_chain (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_res  (w_res)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign w_out_load = (r_state == ST_FIN) && (!r_out_valid || !i_out_stall);

    assign w_dt_raw = i_time_ms - r_last_time;
    assign w_dt     = (w_dt_raw inside {[32'd1 : DT_MAX]}) ? w_dt_raw[DT_W-1:0] : DT_DEF;

    assign w_ax_sc = VW'(r_ax) <<< VEC_SHIFT;
    assign w_ay_sc = VW'(r_ay) <<< VEC_SHIFT;
    assign w_az_sc = VW'(r_az) <<< VEC_SHIFT;

    assign w_req = '{
        valid: (r_state inside {ST_ROLL, ST_PINJ}),
        x:     (r_state == ST_ROLL) ? w_az_sc : r_len,
        y:     (r_state == ST_ROLL) ? w_ay_sc : -w_ax_sc
    };

    // shared multiplier operands
    always_comb begin
        case (r_state)
            ST_ROLL: begin
                w_mul_a = MOP_W'(r_gx);
                w_mul_b = MOP_W'($signed({1'b0, r_dt}));
            end
            ST_GXP: begin
                w_mul_a = MOP_W'(r_gy);
                w_mul_b = MOP_W'($signed({1'b0, r_dt}));
            end
            ST_GX, ST_GY: begin
                w_mul_a = MOP_W'($signed(r_prod[GD_W-1:0]));
                w_mul_b = $signed({1'b0, w_cfg.gain});
            end
            ST_WAIT_R: begin
                w_mul_a = $signed(w_res.mag[MOP_W-1:0]);
                w_mul_b = $signed({3'b000, INV_GAIN_Q30});
            end
            ST_PINJ, ST_PM: begin
                w_mul_a = r_diff;
                w_mul_b = $signed({17'd0, w_cfg.alpha});
            end
            ST_CR: begin
                w_mul_a = MOP_W'(r_roll_angle);
                w_mul_b = CENTI_SCALE;
            end
            ST_CP: begin
                w_mul_a = MOP_W'(r_pitch_angle);
                w_mul_b = CENTI_SCALE;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_angle_sel = (r_state == ST_GXP) ? r_roll_angle : r_pitch_angle;
    assign w_inc       = (r_prod + GYRO_HALF) >>> GYRO_SHIFT;
    assign w_pred_sum  = w_inc + PROD_W'(w_angle_sel);
    assign w_pred      = sat32(w_pred_sum);

    assign w_res_z = w_res.z;
    assign w_acc   = (w_res_z + ACC_HALF) >>> ACC_SHIFT;
    assign w_len   = (r_prod + LEN_HALF) >>> LEN_SHIFT;

    assign w_pred_sel = (r_state == ST_LEN) ? r_pred_r : r_pred_p;
    assign w_mix      = r_prod + (PROD_W'(r_acc) <<< BLEND_FRAC) + BLEND_HALF;
    assign w_blend    = sat32(w_mix >>> BLEND_FRAC);
    assign w_centi    = (r_prod + CENTI_HALF) >>> ANGLE_FRAC;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_ROLL;
            ST_ROLL:   n_state = ST_GX;
            ST_GX:     n_state = ST_GXP;
            ST_GXP:    n_state = ST_GY;
            ST_GY:     n_state = ST_GYP;
            ST_GYP:    n_state = ST_WAIT_R;
            ST_WAIT_R: if (w_res.valid) n_state = ST_LEN;
            ST_LEN:    n_state = ST_PINJ;
            ST_PINJ:   n_state = ST_BR;
            ST_BR:     n_state = ST_CR;
            ST_CR:     n_state = ST_CR2;
            ST_CR2:    n_state = ST_WAIT_P;
            ST_WAIT_P: if (w_res.valid) n_state = ST_PD;
            ST_PD:     n_state = ST_PM;
            ST_PM:     n_state = ST_BP;
            ST_BP:     n_state = ST_CP;
            ST_CP:     n_state = ST_CP2;
            ST_CP2:    n_state = ST_FIN;
            ST_FIN:    if (w_out_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_last_time   <= '0;
            r_roll_angle  <= '0;
            r_pitch_angle <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_last_time <= i_time_ms;
            end
            if (r_state == ST_BR) begin
                r_roll_angle <= w_blend;
            end
            if (r_state == ST_BP) begin
                r_pitch_angle <= w_blend;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        if (w_in_acc) begin
            r_ax <= DIFF_W'(i_accel_x) - DIFF_W'($signed(w_cfg.off_ax));
            r_ay <= DIFF_W'(i_accel_y) - DIFF_W'($signed(w_cfg.off_ay));
            r_az <= DIFF_W'(i_accel_z) - DIFF_W'($signed(w_cfg.off_az));
            r_gx <= DIFF_W'(i_gyro_x) - DIFF_W'($signed(w_cfg.off_gx));
            r_gy <= DIFF_W'(i_gyro_y) - DIFF_W'($signed(w_cfg.off_gy));
            r_dt <= w_dt;
        end
        case (r_state)
            ST_GXP: r_pred_r <= w_pred;
            ST_GYP: r_pred_p <= w_pred;
            ST_WAIT_R, ST_WAIT_P: begin
                if (w_res.valid) r_acc <= w_acc;
            end
            ST_LEN: begin
                r_len  <= $signed(w_len[VW-1:0]);
                r_diff <= MOP_W'(w_pred_sel) - MOP_W'(r_acc);
            end
            ST_PD:  r_diff <= MOP_W'(w_pred_sel) - MOP_W'(r_acc);
            ST_CR2: r_roll_c <= sat_centi(w_centi);
            ST_CP2: r_pitch_c <= sat_centi(w_centi);
            default: ;
        endcase
        if (w_out_load) begin
            r_out_roll  <= r_roll_c;
            r_out_pitch <= r_pitch_c;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_roll_centideg  = r_out_roll;
    assign o_pitch_centideg = r_out_pitch;

    a_chain_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> (r_state == ST_WAIT_R || r_state == ST_WAIT_P))
        else $error("cordic result arrived outside a wait state");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_ROLL))
        else $error("accepted item did not start the roll pass");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_roll <= 16'sd18000 && r_out_roll >= -16'sd18000 &&
                         r_out_pitch <= 16'sd18000 && r_out_pitch >= -16'sd18000))
        else $error("output angle out of range");

    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (r_out_valid && r_state == ST_IDLE))
        else $error("finished item not presented");

endmodule

`default_nettype wire
